FILE: rtl/alex_pkg.sv
// Shared types, token codes and the character classifier of the expression lexer.
`timescale 1ns / 1ps

package alex_pkg;

    // Default width of the digit accumulator.
    localparam int NUMBER_BITS_DEFAULT = 31;

    // Widths of the result fields.
    localparam int KIND_W  = 3;
    localparam int SUB_W   = 2;
    localparam int VALUE_W = 31;
    localparam int POS_W   = 16;

    // Depth of the event queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BRACE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

    // Subcodes for operators and braces.
    localparam logic [SUB_W-1:0] SUB_ADD   = 2'd0;
    localparam logic [SUB_W-1:0] SUB_SUB   = 2'd1;
    localparam logic [SUB_W-1:0] SUB_MUL   = 2'd2;
    localparam logic [SUB_W-1:0] SUB_DIV   = 2'd3;
    localparam logic [SUB_W-1:0] SUB_LEFT  = 2'd0;
    localparam logic [SUB_W-1:0] SUB_RIGHT = 2'd1;
    localparam logic [SUB_W-1:0] SUB_NONE  = 2'd0;

    // Character codes.
    localparam logic [7:0] CHR_NUL    = 8'd0;
    localparam logic [7:0] CHR_TAB    = 8'd9;
    localparam logic [7:0] CHR_CR     = 8'd13;
    localparam logic [7:0] CHR_SPACE  = 8'd32;
    localparam logic [7:0] CHR_LPAREN = 8'd40;
    localparam logic [7:0] CHR_RPAREN = 8'd41;
    localparam logic [7:0] CHR_STAR   = 8'd42;
    localparam logic [7:0] CHR_PLUS   = 8'd43;
    localparam logic [7:0] CHR_MINUS  = 8'd45;
    localparam logic [7:0] CHR_SLASH  = 8'd47;
    localparam logic [7:0] CHR_ZERO   = 8'd48;
    localparam logic [7:0] CHR_NINE   = 8'd57;

    // Classification of one non-digit character.
    typedef struct packed {
        logic              has_tok;
        logic              is_end;
        logic [KIND_W-1:0] kind;
        logic [SUB_W-1:0]  sub;
    } t_class;

    // One queue entry: everything that one accepted character produces.
    typedef struct packed {
        logic               has_num;
        logic [VALUE_W-1:0] num_value;
        logic               has_tok;
        logic [KIND_W-1:0]  tok_kind;
        logic [SUB_W-1:0]   tok_sub;
        logic [POS_W-1:0]   tok_pos;
    } t_entry;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Front state exposed for checking.
    typedef struct packed {
        logic             pending;
        logic [POS_W-1:0] index;
    } t_front_stat;

    // Decode a non-digit character into its token.
    function automatic t_class classify(input logic [7:0] c);
        t_class r;
        r.has_tok = 1'b1;
        r.is_end  = 1'b0;
        r.kind    = KIND_UNKNOWN;
        r.sub     = SUB_NONE;
        unique case (c) inside
            CHR_NUL: begin
                r.is_end = 1'b1;
                r.kind   = KIND_END;
            end
            [CHR_TAB:CHR_CR], CHR_SPACE: begin
                r.has_tok = 1'b0;
            end
            CHR_PLUS: begin
                r.kind = KIND_OPERATOR;
                r.sub  = SUB_ADD;
            end
            CHR_MINUS: begin
                r.kind = KIND_OPERATOR;
                r.sub  = SUB_SUB;
            end
            CHR_STAR: begin
                r.kind = KIND_OPERATOR;
                r.sub  = SUB_MUL;
            end
            CHR_SLASH: begin
                r.kind = KIND_OPERATOR;
                r.sub  = SUB_DIV;
            end
            CHR_LPAREN: begin
                r.kind = KIND_BRACE;
                r.sub  = SUB_LEFT;
            end
            CHR_RPAREN: begin
                r.kind = KIND_BRACE;
                r.sub  = SUB_RIGHT;
            end
            default: begin
                r.kind = KIND_UNKNOWN;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/alex_front.sv
// Front part of the lexer: accepts characters, builds numbers and queues token events.
`timescale 1ns / 1ps

module alex_front
    import alex_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_chr,
    input  t_qstat      i_qstat,
    output logic        o_q_push,
    output t_entry      o_q_entry,
    output t_front_stat o_stat
);

    localparam int PROD_W = NUMBER_BITS + 4;
    localparam int EXT_W  = NUMBER_BITS + VALUE_W;
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic                   r_pending, n_pending;
    logic [POS_W-1:0]       r_index, n_index;

    logic                   accept;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [PROD_W-1:0]      prod;
    logic [EXT_W-1:0]       acc_ext;
    t_class                 cls;

    assign accept   = i_push && !i_qstat.full;
    assign is_digit = (i_chr >= CHR_ZERO) && (i_chr <= CHR_NINE);
    assign digit    = 4'(i_chr - CHR_ZERO);
    assign cls      = classify(i_chr);
    assign acc_ext  = {{VALUE_W{1'b0}}, r_acc};

    // Shift-add by ten with the new digit; saturation when the sum passes the maximum.
    assign prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {{NUMBER_BITS{1'b0}}, digit};

    // Next state and the queue entry for this character.
    always_comb begin
        n_acc     = r_acc;
        n_pending = r_pending;
        n_index   = r_index;
        o_q_push  = 1'b0;

        o_q_entry.has_num   = r_pending;
        o_q_entry.num_value = acc_ext[VALUE_W-1:0];
        o_q_entry.has_tok   = cls.has_tok;
        o_q_entry.tok_kind  = cls.kind;
        o_q_entry.tok_sub   = cls.sub;
        o_q_entry.tok_pos   = (cls.kind == KIND_UNKNOWN) ? r_index : '0;

        if (accept) begin
            n_index = r_index + 1'b1;
            if (is_digit) begin
                n_pending = 1'b1;
                if (prod > {4'b0000, NUM_MAX}) begin
                    n_acc = NUM_MAX;
                end else begin
                    n_acc = prod[NUMBER_BITS-1:0];
                end
            end else begin
                n_acc     = '0;
                n_pending = 1'b0;
                o_q_push  = r_pending || cls.has_tok;
                if (cls.is_end) begin
                    n_index = '0;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pending <= 1'b0;
            r_index   <= '0;
        end else begin
            r_acc     <= n_acc;
            r_pending <= n_pending;
            r_index   <= n_index;
        end
    end

    assign o_stat.pending = r_pending;
    assign o_stat.index   = r_index;

endmodule

FILE: rtl/alex_queue.sv
// Short event queue between the front and back parts of the lexer.
`timescale 1ns / 1ps

module alex_queue
    import alex_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output t_qstat o_qstat
);

    t_entry                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr;
    logic [QUEUE_AW-1:0]   r_rd, n_rd;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_qstat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_entry = r_slot[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr    = do_push ? QUEUE_AW'(r_wr + 1'b1) : r_wr;
        n_rd    = do_pop ? QUEUE_AW'(r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

endmodule

FILE: rtl/alex_back.sv
// Back part of the lexer: splits queued events into single results in an output register.
`timescale 1ns / 1ps

module alex_back
    import alex_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_entry             i_entry,
    input  t_qstat             i_qstat,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [KIND_W-1:0]  o_kind,
    output logic [SUB_W-1:0]   o_subcode,
    output logic [VALUE_W-1:0] o_value,
    output logic [POS_W-1:0]   o_position,
    output logic               o_last
);

    logic               r_valid, n_valid;
    logic               r_second, n_second;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [SUB_W-1:0]   r_sub, n_sub;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_last, n_last;
    logic [KIND_W-1:0]  r_tkind, n_tkind;
    logic [SUB_W-1:0]   r_tsub, n_tsub;
    logic [POS_W-1:0]   r_tpos, n_tpos;
    logic               advance;

    assign advance = !r_valid || i_pop;

    // Choose the next result: the held token of a split event, else the queue head.
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_sub    = r_sub;
        n_value  = r_value;
        n_pos    = r_pos;
        n_last   = r_last;
        n_tkind  = r_tkind;
        n_tsub   = r_tsub;
        n_tpos   = r_tpos;
        o_q_pop  = 1'b0;

        if (advance) begin
            if (r_second) begin
                n_valid  = 1'b1;
                n_second = 1'b0;
                n_kind   = r_tkind;
                n_sub    = r_tsub;
                n_value  = '0;
                n_pos    = r_tpos;
                n_last   = 1'b1;
            end else if (!i_qstat.empty) begin
                o_q_pop = 1'b1;
                n_valid = 1'b1;
                if (i_entry.has_num) begin
                    n_kind   = KIND_NUMBER;
                    n_sub    = SUB_NONE;
                    n_value  = i_entry.num_value;
                    n_pos    = '0;
                    n_last   = !i_entry.has_tok;
                    n_second = i_entry.has_tok;
                    n_tkind  = i_entry.tok_kind;
                    n_tsub   = i_entry.tok_sub;
                    n_tpos   = i_entry.tok_pos;
                end else begin
                    n_kind  = i_entry.tok_kind;
                    n_sub   = i_entry.tok_sub;
                    n_value = '0;
                    n_pos   = i_entry.tok_pos;
                    n_last  = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    // Result and held-token payload.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_sub   <= n_sub;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_last  <= n_last;
        r_tkind <= n_tkind;
        r_tsub  <= n_tsub;
        r_tpos  <= n_tpos;
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_subcode  = r_sub;
    assign o_value    = r_value;
    assign o_position = r_pos;
    assign o_last     = r_last;

endmodule

FILE: rtl/arith_expression_lexer.sv
// Top level of the arithmetic expression lexer.
//
//   Channel   Direction  Handshake          Payload
//   chars     in         push / full        i_chr
//   tokens    out        empty / pop        o_kind o_subcode o_value o_position o_last
//
// One character is accepted per cycle while full is low; the digit shift-add and the token decode
// finish in the front part in that cycle. A character that completes a number and a
// token yields two results, which leave the output register one per cycle while pop
// is high. Each result is registered in the event queue and then in the output
// register. Reset is synchronous and empties the queue and the output register.
// full rises when the four-entry event queue fills because results are popped
// more slowly than they are made.
`timescale 1ns / 1ps

module arith_expression_lexer
    import alex_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_chr,
    output logic               empty,
    input  logic               pop,
    output logic [KIND_W-1:0]  o_kind,
    output logic [SUB_W-1:0]   o_subcode,
    output logic [VALUE_W-1:0] o_value,
    output logic [POS_W-1:0]   o_position,
    output logic               o_last
);

    t_qstat      qstat;
    t_entry      front_entry;
    t_entry      head_entry;
    t_front_stat front_stat;
    logic        q_push;
    logic        q_pop;
    logic        out_valid;

    alex_front #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_chr    (i_chr),
        .i_qstat  (qstat),
        .o_q_push (q_push),
        .o_q_entry(front_entry),
        .o_stat   (front_stat)
    );

    alex_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_entry(front_entry),
        .i_pop  (q_pop),
        .o_entry(head_entry),
        .o_qstat(qstat)
    );

    alex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (head_entry),
        .i_qstat   (qstat),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_kind    (o_kind),
        .o_subcode (o_subcode),
        .o_value   (o_value),
        .o_position(o_position),
        .o_last    (o_last)
    );

    assign full  = qstat.full;
    assign empty = !out_valid;

    // An accepted end-of-expression character returns the front to its reset state.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_chr == CHR_NUL) |=>
            (front_stat.index == '0 && !front_stat.pending))
        else $error("front state not cleared after end of expression");

    // An end result is always the final result of its character.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_END) |-> o_last)
        else $error("end result without last flag");

    // Only number results carry a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_NUMBER) |-> (o_value == '0))
        else $error("nonzero value on a non-number result");

    // Only unknown-symbol results carry a position.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_UNKNOWN) |-> (o_position == '0))
        else $error("nonzero position on a result that is not an error");

endmodule
